// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clk edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/qoi565_pkg.sv =====
// Shared types and constants of the QOI RGB565 line decoder.
// Used by qoi565_ctrl, qoi565_dp and the top level; depends on nothing.
package qoi565_pkg;

  localparam logic [7:0] MAX_LINE_WIDTH   = 8'd240;
  localparam logic [7:0] LINE_WIDTH_RESET = 8'd240;
  localparam logic [7:0] BYTE_LITERAL     = 8'hFE;

  // top two bits of an opcode byte
  localparam logic [1:0] TAG_BAD  = 2'b00;
  localparam logic [1:0] TAG_DIFF = 2'b01;
  localparam logic [1:0] TAG_LUMA = 2'b10;
  localparam logic [1:0] TAG_RUN  = 2'b11;

  // configuration register word index
  localparam logic [0:0] REG_LINE_WIDTH = 1'b0;

  typedef enum logic [1:0] {
    COLOR_KEEP,
    COLOR_LITERAL,
    COLOR_DIFF,
    COLOR_LUMA
  } color_op_t;

  typedef struct packed {
    logic      start_line;  // item carries line_start: reload count, black color
    logic      hold_byte;   // latch code_byte for a two-byte opcode
    color_op_t color_op;
    logic      emit;        // push one pixel into the output register
    logic      bad;         // pixel is from an invalid opcode
    logic      run_load;    // first pixel of a run, load run counter
    logic      run_step;    // further pixel of a run
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;    // output register can take a pixel this cycle
    logic pixels_zero;  // line already complete (line_start applied)
    logic run_more;     // run has pixels left after this one
  } dp_stat_t;

endpackage

// ===== rtl/qoi_rgb565_line_decoder_unit.sv =====
// Top level of the QOI RGB565 line decoder: APB register, controller, datapath.
// Depends on qoi565_pkg, qoi565_ctrl and qoi565_dp.
//
// Takes one encoded byte per item and emits decoded RGB565 pixels. Single-pixel
// opcodes may follow back to back while the output register is free; a run of N
// pixels pushes its first pixel into the output register as its byte is taken,
// then stalls the byte input while the run counter drains the other N-1, one
// pixel per cycle through the output register while pix_stall is low. Literal
// (three bytes) and luma (two bytes) opcodes give their pixel on the last byte.
// line_width (address 0, reset 240, clamped to 240) is loaded into the line
// countdown by a line_start byte; later bytes of a finished line give no output.
module qoi_rgb565_line_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // encoded bytes
  input  logic        code_valid,
  output logic        code_stall,
  input  logic [7:0]  code_byte,
  input  logic        line_start,
  // pixels
  output logic        pix_valid,
  input  logic        pix_stall,
  output logic [15:0] pixel,
  output logic        line_end,
  output logic        run_last,
  output logic        bad_opcode
);

  logic [7:0]           line_width;
  logic                 reg_hit;
  qoi565_pkg::dp_cmd_t  cmd;
  qoi565_pkg::dp_stat_t stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == qoi565_pkg::REG_LINE_WIDTH) && (paddr[1:0] == 2'd0);
  assign prdata  = reg_hit ? {24'd0, line_width} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= qoi565_pkg::LINE_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      line_width <= pwdata[7:0];
    end
  end

  qoi565_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_byte  (code_byte),
    .line_start (line_start),
    .stat       (stat),
    .cmd        (cmd)
  );

  qoi565_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .code_byte  (code_byte),
    .line_start (line_start),
    .cmd        (cmd),
    .stat       (stat),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pixel      (pixel),
    .line_end   (line_end),
    .run_last   (run_last),
    .bad_opcode (bad_opcode)
  );

endmodule

// ===== rtl/qoi565_ctrl.sv =====
// Opcode parser and handshake controller of the QOI RGB565 line decoder.
// Depends on qoi565_pkg; drives commands into qoi565_dp.
module qoi565_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                code_valid,
  output logic                code_stall,
  input  logic [7:0]          code_byte,
  input  logic                line_start,
  input  qoi565_pkg::dp_stat_t stat,
  output qoi565_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIT1,
    ST_LIT2,
    ST_LUMA,
    ST_RUN
  } state_t;

  state_t state, state_next, phase;
  logic   accept;

  always_comb begin
    code_stall = (state == ST_RUN) || !stat.slot_free;
    accept     = code_valid && !code_stall;
    // line_start drops any half-read opcode before this byte is parsed
    phase      = line_start ? ST_IDLE : state;

    cmd            = '0;
    cmd.color_op   = qoi565_pkg::COLOR_KEEP;
    cmd.start_line = accept && line_start;
    state_next     = state;

    if (state == ST_RUN) begin
      if (stat.slot_free) begin
        cmd.emit     = 1'b1;
        cmd.run_step = 1'b1;
        if (!stat.run_more) begin
          state_next = ST_IDLE;
        end
      end
    end else if (accept) begin
      unique case (phase)
        ST_LIT1: begin
          cmd.hold_byte = 1'b1;
          state_next    = ST_LIT2;
        end
        ST_LIT2: begin
          cmd.color_op = qoi565_pkg::COLOR_LITERAL;
          cmd.emit     = 1'b1;
          state_next   = ST_IDLE;
        end
        ST_LUMA: begin
          cmd.color_op = qoi565_pkg::COLOR_LUMA;
          cmd.emit     = 1'b1;
          state_next   = ST_IDLE;
        end
        default: begin
          state_next = ST_IDLE;
          if (!stat.pixels_zero) begin
            if (code_byte == qoi565_pkg::BYTE_LITERAL) begin
              state_next = ST_LIT1;
            end else begin
              unique case (code_byte[7:6])
                qoi565_pkg::TAG_RUN: begin
                  cmd.emit     = 1'b1;
                  cmd.run_load = 1'b1;
                  if (stat.run_more) begin
                    state_next = ST_RUN;
                  end
                end
                qoi565_pkg::TAG_DIFF: begin
                  cmd.color_op = qoi565_pkg::COLOR_DIFF;
                  cmd.emit     = 1'b1;
                end
                qoi565_pkg::TAG_LUMA: begin
                  cmd.hold_byte = 1'b1;
                  state_next    = ST_LUMA;
                end
                default: begin
                  cmd.emit = 1'b1;
                  cmd.bad  = 1'b1;
                end
              endcase
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/qoi565_dp.sv =====
// Datapath of the QOI RGB565 line decoder: color, line count, held byte,
// run counter and output register. Depends on qoi565_pkg; run by qoi565_ctrl.
module qoi565_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          line_width,
  input  logic [7:0]          code_byte,
  input  logic                line_start,
  input  qoi565_pkg::dp_cmd_t  cmd,
  output qoi565_pkg::dp_stat_t stat,
  output logic                pix_valid,
  input  logic                pix_stall,
  output logic [15:0]         pixel,
  output logic                line_end,
  output logic                run_last,
  output logic                bad_opcode
);

  logic [4:0] prev_red, prev_blue;
  logic [5:0] prev_green;
  logic [7:0] pixels_left, held_byte;
  logic [5:0] run_left;

  logic [7:0] width_clamp, base_pl, stat_pl;
  logic [4:0] base_red, base_blue, red_next, blue_next;
  logic [5:0] base_green, green_next, luma_dg;
  logic       run_more;

  always_comb begin
    width_clamp = (line_width > qoi565_pkg::MAX_LINE_WIDTH) ?
                  qoi565_pkg::MAX_LINE_WIDTH : line_width;
    base_pl     = cmd.start_line ? width_clamp : pixels_left;
    stat_pl     = line_start ? width_clamp : pixels_left;
    base_red    = cmd.start_line ? 5'd0 : prev_red;
    base_green  = cmd.start_line ? 6'd0 : prev_green;
    base_blue   = cmd.start_line ? 5'd0 : prev_blue;
    luma_dg     = held_byte[5:0] ^ 6'h20;  // gggggg - 32, mod 64

    unique case (cmd.color_op)
      qoi565_pkg::COLOR_LITERAL: begin
        red_next   = held_byte[7:3];
        green_next = {held_byte[2:0], code_byte[7:5]};
        blue_next  = code_byte[4:0];
      end
      qoi565_pkg::COLOR_DIFF: begin
        red_next   = base_red + {3'd0, code_byte[5:4]} + 5'd30;
        green_next = base_green + {4'd0, code_byte[3:2]} + 6'd62;
        blue_next  = base_blue + {3'd0, code_byte[1:0]} + 5'd30;
      end
      qoi565_pkg::COLOR_LUMA: begin
        // red/blue: dg + nibble - 8, taken mod 32
        green_next = base_green + luma_dg;
        red_next   = base_red + luma_dg[4:0] + {1'b0, code_byte[7:4]} + 5'd24;
        blue_next  = base_blue + luma_dg[4:0] + {1'b0, code_byte[3:0]} + 5'd24;
      end
      default: begin
        red_next   = base_red;
        green_next = base_green;
        blue_next  = base_blue;
      end
    endcase

    if (cmd.run_load) begin
      run_more = (code_byte[5:0] != 6'd0) && (base_pl > 8'd1);
    end else begin
      run_more = (run_left > 6'd1) && (pixels_left > 8'd1);
    end

    stat.slot_free   = !pix_valid || !pix_stall;
    stat.pixels_zero = (stat_pl == 8'd0);
    stat.run_more    = run_more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_red    <= '0;
      prev_green  <= '0;
      prev_blue   <= '0;
      pixels_left <= '0;
      held_byte   <= '0;
      pix_valid   <= 1'b0;
    end else begin
      prev_red   <= red_next;
      prev_green <= green_next;
      prev_blue  <= blue_next;
      if (cmd.emit) begin
        pixels_left <= base_pl - {7'd0, (base_pl != 8'd0)};
      end else if (cmd.start_line) begin
        pixels_left <= base_pl;
      end
      if (cmd.hold_byte) begin
        held_byte <= code_byte;
      end
      if (cmd.emit) begin
        pix_valid <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (cmd.run_load) begin
      run_left <= code_byte[5:0];
    end else if (cmd.run_step) begin
      run_left <= run_left - 6'd1;
    end
    if (cmd.emit) begin
      pixel      <= cmd.bad ? 16'd0 : {red_next, green_next, blue_next};
      line_end   <= (base_pl <= 8'd1);
      run_last   <= !((cmd.run_load || cmd.run_step) && run_more);
      bad_opcode <= cmd.bad;
    end
  end

endmodule

// ===== rtl/qoi565_chk.sv =====
// Port-level checks of the QOI RGB565 line decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module qoi565_chk (
  input logic        clk,
  input logic        rst,
  input logic        pix_valid,
  input logic        pix_stall,
  input logic [15:0] pixel,
  input logic        line_end,
  input logic        run_last,
  input logic        bad_opcode
);

  `ASSERT_CLK(a_reset_empty, rst |=> !pix_valid, "pixel output valid right after reset")
  `ASSERT_CLK_NORST(a_bad_black, pix_valid && bad_opcode |-> pixel == 16'd0, "bad opcode pixel not black")
  // a run is always cut at the end of the line
  `ASSERT_CLK_NORST(a_end_is_last, pix_valid && line_end |-> run_last, "line end without run_last")
  `ASSERT_CLK_NORST(a_stall_hold, pix_valid && pix_stall |=> pix_valid && $stable(pixel), "stalled pixel changed")

endmodule

bind qoi_rgb565_line_decoder_unit qoi565_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .pix_valid  (pix_valid),
  .pix_stall  (pix_stall),
  .pixel      (pixel),
  .line_end   (line_end),
  .run_last   (run_last),
  .bad_opcode (bad_opcode)
);
